[rtl/core/rgbcrt_pkg.sv]
// Shared widths, register indexes, format codes and constants for the
// RGB565 crop/resize tensorizer. No dependencies.
`timescale 1ns / 1ps

package rgbcrt_pkg;

  // Frame and output size limits
  localparam int MAX_FRAME_DIM = 2048;
  localparam int MAX_OUT_DIM   = 512;

  localparam int FRAME_DIM_W = 12;   // holds 1..MAX_FRAME_DIM
  localparam int OUT_DIM_W   = 10;   // holds 1..MAX_OUT_DIM
  localparam int SRC_POS_W   = 11;   // source column / row
  localparam int OFFSET_W    = 11;   // crop offset
  localparam int QUOT_W      = 12;   // floor(k*side/n), at most side
  localparam int DIVIDEND_W  = 22;   // k*side
  localparam int DIV_STEPS   = DIVIDEND_W;

  // Payload widths
  localparam int PIXEL_W = 16;
  localparam int CHAN_W  = 17;
  localparam int COORD_W = 9;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_FORMAT   = 3'd4;

  localparam logic [1:0] FMT_UNSIGNED = 2'd0;
  localparam logic [1:0] FMT_OFFSET   = 2'd1;
  localparam logic [1:0] FMT_Q15      = 2'd2;

  // Reset values of the registers
  localparam logic [FRAME_DIM_W-1:0] RST_FRAME_WIDTH  = 12'd320;
  localparam logic [FRAME_DIM_W-1:0] RST_FRAME_HEIGHT = 12'd240;
  localparam logic [OUT_DIM_W-1:0]   RST_OUT_WIDTH    = 10'd96;
  localparam logic [OUT_DIM_W-1:0]   RST_OUT_HEIGHT   = 10'd96;

  // Reciprocals for division by constants:
  //   floor(y/31) = (y*265) >> 13 for y <= 217
  //   floor(x/21) = (x*49)  >> 10 for x <= 63
  //   floor(w/255) = (w*32897) >> 23 for w < 32768
  localparam int EXP5_RECIP = 265;
  localparam int EXP6_RECIP = 49;
  localparam int Q15_RECIP  = 32897;

  typedef struct packed {
    logic signed [CHAN_W-1:0] red;
    logic signed [CHAN_W-1:0] green;
    logic signed [CHAN_W-1:0] blue;
    logic [COORD_W-1:0]       out_x;
    logic [COORD_W-1:0]       out_y;
    logic                     last_of_frame;
  } res_t;

endpackage

[rtl/core/rgbcrt_ifs.sv]
// Stream channel interfaces: source pixels in, tensor results out.
// Depends on rgbcrt_pkg.
`timescale 1ns / 1ps

interface rgbcrt_pix_if;
  logic                               valid;
  logic                               ready;
  logic [rgbcrt_pkg::PIXEL_W-1:0]     pixel;
  logic                               first_of_frame;

  modport source (output valid, pixel, first_of_frame, input ready);
  modport sink   (input valid, pixel, first_of_frame, output ready);
endinterface

interface rgbcrt_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [rgbcrt_pkg::CHAN_W-1:0] red;
  logic signed [rgbcrt_pkg::CHAN_W-1:0] green;
  logic signed [rgbcrt_pkg::CHAN_W-1:0] blue;
  logic [rgbcrt_pkg::COORD_W-1:0]      out_x;
  logic [rgbcrt_pkg::COORD_W-1:0]      out_y;
  logic                                last_of_frame;

  modport source (output valid, red, green, blue, out_x, out_y, last_of_frame, input ready);
  modport sink   (input valid, red, green, blue, out_x, out_y, last_of_frame, output ready);
endinterface

[rtl/core/rgbcrt_div.sv]
// Restoring divider, one quotient bit per step: k*side by output size.
// Depends on rgbcrt_pkg.
`timescale 1ns / 1ps

module rgbcrt_div (
  input  logic                                 clk,
  input  logic                                 load,
  input  logic                                 step,
  input  logic [rgbcrt_pkg::DIVIDEND_W-1:0]    dividend,
  input  logic [rgbcrt_pkg::OUT_DIM_W-1:0]     divisor,
  output logic [rgbcrt_pkg::QUOT_W-1:0]        quotient,
  output logic [rgbcrt_pkg::OUT_DIM_W-1:0]     remainder
);

  logic [rgbcrt_pkg::DIVIDEND_W-1:0] acc;
  logic [rgbcrt_pkg::OUT_DIM_W-1:0]  rem;
  logic [rgbcrt_pkg::OUT_DIM_W-1:0]  div_reg;
  logic [rgbcrt_pkg::OUT_DIM_W:0]    rem_sh;
  logic [rgbcrt_pkg::OUT_DIM_W:0]    rem_sub;
  logic                              fits;

  always_comb begin
    rem_sh  = {rem, acc[rgbcrt_pkg::DIVIDEND_W-1]};
    fits    = rem_sh >= {1'b0, div_reg};
    rem_sub = rem_sh - {1'b0, div_reg};
  end

  // quotient bits shift in at the bottom as the dividend shifts out the top
  always_ff @(posedge clk) begin
    if (load) begin
      acc     <= dividend;
      rem     <= '0;
      div_reg <= divisor;
    end else if (step) begin
      rem <= fits ? rem_sub[rgbcrt_pkg::OUT_DIM_W-1:0] : rem_sh[rgbcrt_pkg::OUT_DIM_W-1:0];
      acc <= {acc[rgbcrt_pkg::DIVIDEND_W-2:0], fits};
    end
  end

  assign quotient  = acc[rgbcrt_pkg::QUOT_W-1:0];
  assign remainder = rem;

endmodule

[rtl/core/rgb565_crop_resize_tensorizer.sv]
// Top level: centred square crop, nearest-neighbour downscale, RGB565 to
// 8-bit channels in one of three formats. Depends on rgbcrt_pkg,
// rgbcrt_ifs and rgbcrt_div.
`timescale 1ns / 1ps

//  channel   dir  handshake      payload
//  pixels    in   valid/ready    pixel[15:0], first_of_frame
//  results   out  valid/ready    red/green/blue[16:0] s, out_x, out_y, last_of_frame
//  cfg       in   cfg_write      cfg_index[2:0], cfg_data[11:0]
//
//  One pixel transfer per cycle while ready is high; a chosen pixel's result is written into the result queue.
//  A two-entry result queue lets pixels keep flowing while one result waits.
//  After reset and after every register write, the sampling steps are rebuilt
//  by four serial dividers: ready stays low through the geometry, load,
//  divide-step and fetch phases.
//  rst is synchronous and restores the register defaults and counters.

module rgb565_crop_resize_tensorizer (
  input  logic                                 clk,
  input  logic                                 rst,
  rgbcrt_pix_if.sink                           pixels,
  rgbcrt_res_if.source                         results,
  input  logic                                 cfg_write,
  input  logic [rgbcrt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rgbcrt_pkg::CFG_DATA_W-1:0]    cfg_data
);

  typedef enum logic [2:0] {ST_GEOM, ST_LOAD, ST_DIV, ST_FETCH, ST_RUN} phase_t;

  typedef struct packed {
    logic [rgbcrt_pkg::FRAME_DIM_W-1:0] fw;
    logic [rgbcrt_pkg::FRAME_DIM_W-1:0] fh;
    logic [rgbcrt_pkg::FRAME_DIM_W-1:0] side;
    logic [rgbcrt_pkg::OFFSET_W-1:0]    cx;
    logic [rgbcrt_pkg::OFFSET_W-1:0]    cy;
    logic [rgbcrt_pkg::OUT_DIM_W-1:0]   ow;
    logic [rgbcrt_pkg::OUT_DIM_W-1:0]   oh;
  } geom_t;

  // ------------------------------------------------------------------
  // Registers
  logic [rgbcrt_pkg::FRAME_DIM_W-1:0] frame_width, frame_height;
  logic [rgbcrt_pkg::OUT_DIM_W-1:0]   out_width, out_height;
  logic [1:0]                         out_format;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= rgbcrt_pkg::RST_FRAME_WIDTH;
      frame_height <= rgbcrt_pkg::RST_FRAME_HEIGHT;
      out_width    <= rgbcrt_pkg::RST_OUT_WIDTH;
      out_height   <= rgbcrt_pkg::RST_OUT_HEIGHT;
      out_format   <= rgbcrt_pkg::FMT_UNSIGNED;
    end else if (cfg_write) begin
      case (cfg_index)
        rgbcrt_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        rgbcrt_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        rgbcrt_pkg::REG_OUT_WIDTH:    out_width    <= cfg_data[rgbcrt_pkg::OUT_DIM_W-1:0];
        rgbcrt_pkg::REG_OUT_HEIGHT:   out_height   <= cfg_data[rgbcrt_pkg::OUT_DIM_W-1:0];
        rgbcrt_pkg::REG_OUT_FORMAT:   out_format   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Geometry from the registers, latched before the dividers run
  geom_t geom, geom_next;

  always_comb begin
    geom_next = '0;
    if (frame_width == '0)
      geom_next.fw = 12'd1;
    else if (frame_width > 12'(rgbcrt_pkg::MAX_FRAME_DIM))
      geom_next.fw = 12'(rgbcrt_pkg::MAX_FRAME_DIM);
    else
      geom_next.fw = frame_width;
    if (frame_height == '0)
      geom_next.fh = 12'd1;
    else if (frame_height > 12'(rgbcrt_pkg::MAX_FRAME_DIM))
      geom_next.fh = 12'(rgbcrt_pkg::MAX_FRAME_DIM);
    else
      geom_next.fh = frame_height;
    geom_next.side = (geom_next.fw < geom_next.fh) ? geom_next.fw : geom_next.fh;
    geom_next.cx   = 11'((geom_next.fw - geom_next.side) >> 1);
    geom_next.cy   = 11'((geom_next.fh - geom_next.side) >> 1);
    if (out_width == '0)
      geom_next.ow = 10'd1;
    else if (out_width > 10'(rgbcrt_pkg::MAX_OUT_DIM))
      geom_next.ow = 10'(rgbcrt_pkg::MAX_OUT_DIM);
    else
      geom_next.ow = out_width;
    if (out_height == '0)
      geom_next.oh = 10'd1;
    else if (out_height > 10'(rgbcrt_pkg::MAX_OUT_DIM))
      geom_next.oh = 10'(rgbcrt_pkg::MAX_OUT_DIM);
    else
      geom_next.oh = out_height;
    // no upscaling: output never larger than the crop side
    if ({2'b00, geom_next.ow} > geom_next.side)
      geom_next.ow = geom_next.side[rgbcrt_pkg::OUT_DIM_W-1:0];
    if ({2'b00, geom_next.oh} > geom_next.side)
      geom_next.oh = geom_next.side[rgbcrt_pkg::OUT_DIM_W-1:0];
  end

  // ------------------------------------------------------------------
  // Sampling state
  logic [rgbcrt_pkg::SRC_POS_W-1:0]   src_col, src_row;
  logic [rgbcrt_pkg::OUT_DIM_W-1:0]   next_col, next_row;
  logic [rgbcrt_pkg::FRAME_DIM_W-1:0] want_col, want_row;
  logic [rgbcrt_pkg::QUOT_W-1:0]      col_quot, row_quot;       // floor(next*side/n)
  logic [rgbcrt_pkg::OUT_DIM_W-1:0]   col_remainder, row_remainder;

  // ------------------------------------------------------------------
  // Step dividers: side/n and next*side/n for columns and rows
  phase_t    phase;
  logic [4:0] div_cnt;
  logic      div_load, div_step;

  logic [rgbcrt_pkg::QUOT_W-1:0]    col_pos_q, col_step_q, row_pos_q, row_step_q;
  logic [rgbcrt_pkg::OUT_DIM_W-1:0] col_pos_r, col_step_r, row_pos_r, row_step_r;

  assign div_load = (phase == ST_LOAD);
  assign div_step = (phase == ST_DIV);

  rgbcrt_div u_col_pos (
    .clk       (clk),
    .load      (div_load),
    .step      (div_step),
    .dividend  (22'(next_col) * 22'(geom.side)),
    .divisor   (geom.ow),
    .quotient  (col_pos_q),
    .remainder (col_pos_r)
  );

  rgbcrt_div u_col_step (
    .clk       (clk),
    .load      (div_load),
    .step      (div_step),
    .dividend  (22'(geom.side)),
    .divisor   (geom.ow),
    .quotient  (col_step_q),
    .remainder (col_step_r)
  );

  rgbcrt_div u_row_pos (
    .clk       (clk),
    .load      (div_load),
    .step      (div_step),
    .dividend  (22'(next_row) * 22'(geom.side)),
    .divisor   (geom.oh),
    .quotient  (row_pos_q),
    .remainder (row_pos_r)
  );

  rgbcrt_div u_row_step (
    .clk       (clk),
    .load      (div_load),
    .step      (div_step),
    .dividend  (22'(geom.side)),
    .divisor   (geom.oh),
    .quotient  (row_step_q),
    .remainder (row_step_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= ST_GEOM;
      div_cnt <= '0;
    end else if (cfg_write) begin
      phase <= ST_GEOM;
    end else begin
      case (phase)
        ST_GEOM:  phase <= ST_LOAD;
        ST_LOAD: begin
          phase   <= ST_DIV;
          div_cnt <= '0;
        end
        ST_DIV: begin
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'(rgbcrt_pkg::DIV_STEPS - 1))
            phase <= ST_FETCH;
        end
        ST_FETCH: phase <= ST_RUN;
        ST_RUN:   phase <= ST_RUN;
        default:  phase <= ST_GEOM;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (phase == ST_GEOM)
      geom <= geom_next;
  end

  // ------------------------------------------------------------------
  // Channel expansion and formatting
  function automatic logic [7:0] expand5(input logic [4:0] x);
    logic [7:0]  y;
    logic [16:0] p;
    begin
      y = {x, 3'b000} - {3'b000, x};
      p = 17'(y) * 17'(rgbcrt_pkg::EXP5_RECIP);
      expand5 = {x, 3'b000} + {5'b00000, p[15:13]};
    end
  endfunction

  function automatic logic [7:0] expand6(input logic [5:0] x);
    logic [11:0] p;
    begin
      p = 12'(x) * 12'(rgbcrt_pkg::EXP6_RECIP);
      expand6 = {x, 2'b00} + {6'b000000, p[11:10]};
    end
  endfunction

  // Q1.15: (c*32768 + 127)/255 = 128*c + floor((128*c + 127)/255)
  function automatic logic signed [16:0] fmt_chan(input logic [7:0] c8, input logic [1:0] fmt);
    logic [14:0] w;
    logic [30:0] p;
    logic [15:0] q15;
    begin
      w   = {c8, 7'h7f};
      p   = 31'(w) * 31'(rgbcrt_pkg::Q15_RECIP);
      q15 = {1'b0, c8, 7'b0000000} + {8'b00000000, p[30:23]};
      case (fmt)
        rgbcrt_pkg::FMT_OFFSET: fmt_chan = $signed({9'b0, c8}) - 17'sd128;
        rgbcrt_pkg::FMT_Q15:    fmt_chan = $signed({1'b0, q15});
        default:                fmt_chan = $signed({9'b0, c8});
      endcase
    end
  endfunction

  // ------------------------------------------------------------------
  // Per-pixel step
  logic accept, start, row_hit, col_hit, col_end;
  logic [rgbcrt_pkg::SRC_POS_W-1:0]   sc, sr;
  logic [rgbcrt_pkg::OUT_DIM_W-1:0]   nc, nr, nc_inc, nr_inc;
  logic [rgbcrt_pkg::FRAME_DIM_W-1:0] wc, wr;
  logic [rgbcrt_pkg::QUOT_W-1:0]      cq, rq, cq_inc, rq_inc;
  logic [rgbcrt_pkg::OUT_DIM_W-1:0]   cr, rr, cr_inc, rr_inc;
  logic [rgbcrt_pkg::OUT_DIM_W:0]     csum, rsum;
  logic                               ccarry, rcarry;

  logic [rgbcrt_pkg::SRC_POS_W-1:0]   src_col_next, src_row_next;
  logic [rgbcrt_pkg::OUT_DIM_W-1:0]   next_col_next, next_row_next;
  logic [rgbcrt_pkg::FRAME_DIM_W-1:0] want_col_next, want_row_next;
  logic [rgbcrt_pkg::QUOT_W-1:0]      col_quot_next, row_quot_next;
  logic [rgbcrt_pkg::OUT_DIM_W-1:0]   col_remainder_next, row_remainder_next;
  rgbcrt_pkg::res_t                   res_new;

  assign accept = pixels.valid && pixels.ready;

  always_comb begin
    start = pixels.first_of_frame || (src_col == '0 && src_row == '0);
    if (start) begin
      sc = '0;
      sr = '0;
      nc = '0;
      nr = '0;
      wc = {1'b0, geom.cx};
      wr = {1'b0, geom.cy};
      cq = '0;
      rq = '0;
      cr = '0;
      rr = '0;
    end else begin
      sc = src_col;
      sr = src_row;
      nc = next_col;
      nr = next_row;
      wc = want_col;
      wr = want_row;
      cq = col_quot;
      rq = row_quot;
      cr = col_remainder;
      rr = row_remainder;
    end

    row_hit = (nr < geom.oh) && ({1'b0, sr} == wr);
    col_hit = row_hit && (nc < geom.ow) && ({1'b0, sc} == wc);

    // incremental floor((k+1)*side/n) from floor(k*side/n)
    nc_inc = nc + 10'd1;
    csum   = {1'b0, cr} + {1'b0, col_step_r};
    ccarry = csum >= {1'b0, geom.ow};
    cr_inc = ccarry ? 10'(csum - {1'b0, geom.ow}) : csum[rgbcrt_pkg::OUT_DIM_W-1:0];
    cq_inc = cq + col_step_q + {11'b0, ccarry};

    nr_inc = nr + 10'd1;
    rsum   = {1'b0, rr} + {1'b0, row_step_r};
    rcarry = rsum >= {1'b0, geom.oh};
    rr_inc = rcarry ? 10'(rsum - {1'b0, geom.oh}) : rsum[rgbcrt_pkg::OUT_DIM_W-1:0];
    rq_inc = rq + row_step_q + {11'b0, rcarry};

    src_col_next       = sc;
    src_row_next       = sr;
    next_col_next      = nc;
    next_row_next      = nr;
    want_col_next      = wc;
    want_row_next      = wr;
    col_quot_next      = cq;
    row_quot_next      = rq;
    col_remainder_next = cr;
    row_remainder_next = rr;

    if (col_hit) begin
      next_col_next      = nc_inc;
      col_quot_next      = cq_inc;
      col_remainder_next = cr_inc;
      if (nc_inc < geom.ow)
        want_col_next = 12'({1'b0, geom.cx} + cq_inc);
    end

    col_end = ({1'b0, sc} + 12'd1) >= geom.fw;
    if (col_end) begin
      src_col_next = '0;
      if (row_hit) begin
        next_row_next      = nr_inc;
        next_col_next      = '0;
        want_col_next      = {1'b0, geom.cx};
        col_quot_next      = '0;
        col_remainder_next = '0;
        row_quot_next      = rq_inc;
        row_remainder_next = rr_inc;
        if (nr_inc < geom.oh)
          want_row_next = 12'({1'b0, geom.cy} + rq_inc);
      end
      if (({1'b0, sr} + 12'd1) >= geom.fh)
        src_row_next = '0;
      else
        src_row_next = sr + 11'd1;
    end else begin
      src_col_next = sc + 11'd1;
    end

    res_new.red   = fmt_chan(expand5(pixels.pixel[15:11]), out_format);
    res_new.green = fmt_chan(expand6(pixels.pixel[10:5]), out_format);
    res_new.blue  = fmt_chan(expand5(pixels.pixel[4:0]), out_format);
    res_new.out_x = nc[rgbcrt_pkg::COORD_W-1:0];
    res_new.out_y = nr[rgbcrt_pkg::COORD_W-1:0];
    res_new.last_of_frame = (nc_inc == geom.ow) && (nr_inc == geom.oh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_col       <= '0;
      src_row       <= '0;
      next_col      <= '0;
      next_row      <= '0;
      want_col      <= '0;
      want_row      <= '0;
      col_quot      <= '0;
      row_quot      <= '0;
      col_remainder <= '0;
      row_remainder <= '0;
    end else if (phase == ST_FETCH) begin
      // re-base the running quotients on the new geometry
      col_quot      <= col_pos_q;
      col_remainder <= col_pos_r;
      row_quot      <= row_pos_q;
      row_remainder <= row_pos_r;
    end else if (accept) begin
      src_col       <= src_col_next;
      src_row       <= src_row_next;
      next_col      <= next_col_next;
      next_row      <= next_row_next;
      want_col      <= want_col_next;
      want_row      <= want_row_next;
      col_quot      <= col_quot_next;
      row_quot      <= row_quot_next;
      col_remainder <= col_remainder_next;
      row_remainder <= row_remainder_next;
    end
  end

  // ------------------------------------------------------------------
  // Two-entry result queue
  rgbcrt_pkg::res_t res_q [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       res_cnt;
  logic             push, pop;

  assign push = accept && col_hit;
  assign pop  = results.valid && results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= 1'b0;
      rd_ptr  <= 1'b0;
      res_cnt <= '0;
    end else begin
      if (push)
        wr_ptr <= ~wr_ptr;
      if (pop)
        rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   res_cnt <= res_cnt + 2'd1;
        2'b01:   res_cnt <= res_cnt - 2'd1;
        default: res_cnt <= res_cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push)
      res_q[wr_ptr] <= res_new;
  end

  assign pixels.ready          = (phase == ST_RUN) && (res_cnt != 2'd2);
  assign results.valid         = (res_cnt != 2'd0);
  assign results.red           = res_q[rd_ptr].red;
  assign results.green         = res_q[rd_ptr].green;
  assign results.blue          = res_q[rd_ptr].blue;
  assign results.out_x         = res_q[rd_ptr].out_x;
  assign results.out_y         = res_q[rd_ptr].out_y;
  assign results.last_of_frame = res_q[rd_ptr].last_of_frame;

endmodule

[bench/rgb565_crop_resize_tensorizer_tb.sv]
// Self-checking bench for rgb565_crop_resize_tensorizer: directed frames, extreme
// geometries and random phases checked against a behavioural copy of the sampler.
// Depends on rgbcrt_pkg, rgbcrt_ifs and the top level.
`timescale 1ns / 1ps

module rgb565_crop_resize_tensorizer_tb;

  localparam int DRAIN_CYCLES  = 8;
  localparam int RANDOM_PIXELS = 300;
  localparam int IDLE_PCT      = 14;
  localparam int CALM_FROM     = 400;
  localparam int CALM_TO       = 1400;
  localparam logic [1:0] FMT_ALIAS = 2'd3;                            // decoded as unsigned
  localparam logic [rgbcrt_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;      // nothing behind it

  typedef enum logic {ITEM_PIXEL, ITEM_CFG} item_kind_t;

  typedef logic [rgbcrt_pkg::CFG_DATA_W-1:0] cfg_word_t;
  typedef logic [rgbcrt_pkg::PIXEL_W-1:0]    pixel_t;

  typedef struct {
    item_kind_t                         kind;
    logic [rgbcrt_pkg::PIXEL_W-1:0]     pixel;
    logic                               first;
    logic [rgbcrt_pkg::CFG_IDX_W-1:0]   index;
    logic [rgbcrt_pkg::CFG_DATA_W-1:0]  data;
  } stim_t;

  typedef struct {
    logic [rgbcrt_pkg::FRAME_DIM_W-1:0] fw;
    logic [rgbcrt_pkg::FRAME_DIM_W-1:0] fh;
    logic [rgbcrt_pkg::OUT_DIM_W-1:0]   ow;
    logic [rgbcrt_pkg::OUT_DIM_W-1:0]   oh;
    logic [1:0]                         fmt;
  } regs_t;

  typedef struct {
    int unsigned fw, fh, side, cx, cy, ow, oh;
  } geom_t;

  localparam regs_t REGS_AT_RESET = '{rgbcrt_pkg::RST_FRAME_WIDTH,
                                      rgbcrt_pkg::RST_FRAME_HEIGHT,
                                      rgbcrt_pkg::RST_OUT_WIDTH,
                                      rgbcrt_pkg::RST_OUT_HEIGHT,
                                      rgbcrt_pkg::FMT_UNSIGNED};

  logic                                clk = 1'b0;
  logic                                rst;
  logic                                cfg_write;
  logic [rgbcrt_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [rgbcrt_pkg::CFG_DATA_W-1:0]   cfg_data;

  rgbcrt_pix_if pix_ch();
  rgbcrt_res_if res_ch();

  rgb565_crop_resize_tensorizer u_dut (
    .clk       (clk),
    .rst       (rst),
    .pixels    (pix_ch),
    .results   (res_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  stim_t             pending_q[$];
  rgbcrt_pkg::res_t  expected_q[$];
  regs_t plan_regs = REGS_AT_RESET;
  regs_t model_regs;
  int    n_queued, n_sent, n_taken, n_fail;
  int    quiet, tick;
  bit    calm;

  // sampler position, mirrored from the block
  int unsigned col_pos, row_pos, out_col, out_row, want_col, want_row;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic geom_t crop_geometry(regs_t r);
    geom_t g;
    g.fw   = clamp_dim(32'(r.fw), rgbcrt_pkg::MAX_FRAME_DIM);
    g.fh   = clamp_dim(32'(r.fh), rgbcrt_pkg::MAX_FRAME_DIM);
    g.side = (g.fw < g.fh) ? g.fw : g.fh;
    g.cx   = (g.fw - g.side) / 2;
    g.cy   = (g.fh - g.side) / 2;
    g.ow   = clamp_dim(32'(r.ow), rgbcrt_pkg::MAX_OUT_DIM);
    g.oh   = clamp_dim(32'(r.oh), rgbcrt_pkg::MAX_OUT_DIM);
    if (g.ow > g.side) g.ow = g.side;
    if (g.oh > g.side) g.oh = g.side;
    return g;
  endfunction

  function automatic regs_t write_reg(regs_t r, logic [rgbcrt_pkg::CFG_IDX_W-1:0] idx,
                                      logic [rgbcrt_pkg::CFG_DATA_W-1:0] d);
    case (idx)
      rgbcrt_pkg::REG_FRAME_WIDTH:  r.fw  = d;
      rgbcrt_pkg::REG_FRAME_HEIGHT: r.fh  = d;
      rgbcrt_pkg::REG_OUT_WIDTH:    r.ow  = d[rgbcrt_pkg::OUT_DIM_W-1:0];
      rgbcrt_pkg::REG_OUT_HEIGHT:   r.oh  = d[rgbcrt_pkg::OUT_DIM_W-1:0];
      rgbcrt_pkg::REG_OUT_FORMAT:   r.fmt = d[1:0];
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic signed [rgbcrt_pkg::CHAN_W-1:0] scale_channel(int unsigned c8,
                                                                        logic [1:0] fmt);
    int v;
    case (fmt)
      rgbcrt_pkg::FMT_OFFSET: v = int'(c8) - 128;
      rgbcrt_pkg::FMT_Q15:    v = int'((c8 * 32768 + 127) / 255);
      default:                v = int'(c8);
    endcase
    return v[rgbcrt_pkg::CHAN_W-1:0];
  endfunction

  // One source pixel through the crop/resize sampler; queues the tensor
  // element it produces, if any.
  task automatic sample_pixel(logic [rgbcrt_pkg::PIXEL_W-1:0] px, logic first);
    geom_t            g;
    rgbcrt_pkg::res_t r;
    bit               row_hit;
    int unsigned      r8, g8, b8;
    g = crop_geometry(model_regs);
    if (first || (col_pos == 0 && row_pos == 0)) begin
      col_pos  = 0;
      row_pos  = 0;
      out_col  = 0;
      out_row  = 0;
      want_col = g.cx;
      want_row = g.cy;
    end
    row_hit = (out_row < g.oh) && (row_pos == want_row);
    if (row_hit && out_col < g.ow && col_pos == want_col) begin
      r8 = int'(px[15:11]) * 255 / 31;
      g8 = int'(px[10:5]) * 255 / 63;
      b8 = int'(px[4:0]) * 255 / 31;
      r.red           = scale_channel(r8, model_regs.fmt);
      r.green         = scale_channel(g8, model_regs.fmt);
      r.blue          = scale_channel(b8, model_regs.fmt);
      r.out_x         = out_col[rgbcrt_pkg::COORD_W-1:0];
      r.out_y         = out_row[rgbcrt_pkg::COORD_W-1:0];
      r.last_of_frame = (out_col + 1 == g.ow) && (out_row + 1 == g.oh);
      expected_q.push_back(r);
      out_col++;
      if (out_col < g.ow) want_col = g.cx + out_col * g.side / g.ow;
    end
    if (col_pos + 1 >= g.fw) begin
      col_pos = 0;
      if (row_hit) begin
        out_row++;
        out_col  = 0;
        want_col = g.cx;
        if (out_row < g.oh) want_row = g.cy + out_row * g.side / g.oh;
      end
      row_pos = (row_pos + 1 >= g.fh) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endtask

  task automatic check_field(string name, logic signed [31:0] want,
                             logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic push_pixel(logic [rgbcrt_pkg::PIXEL_W-1:0] px, logic first);
    pending_q.push_back('{ITEM_PIXEL, px, first, '0, '0});
    n_queued++;
  endtask

  task automatic push_cfg(logic [rgbcrt_pkg::CFG_IDX_W-1:0] idx,
                          logic [rgbcrt_pkg::CFG_DATA_W-1:0] d);
    pending_q.push_back('{ITEM_CFG, '0, 1'b0, idx, d});
    plan_regs = write_reg(plan_regs, idx, d);
  endtask

  function automatic logic [rgbcrt_pkg::PIXEL_W-1:0] random_pixel();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return pixel_t'($urandom_range(0, 65535));
    endcase
  endfunction

  // stray frame marks at noise_pm per mille
  task automatic stream_frame(int unsigned npix, bit marked, int unsigned noise_pm);
    for (int unsigned i = 0; i < npix; i++)
      push_pixel(random_pixel(), (marked && i == 0) || $urandom_range(0, 999) < noise_pm);
  endtask

  function automatic int unsigned rand_dim();
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return $urandom_range(11, 24);
      default: return $urandom_range(1, 10);
    endcase
  endfunction

  function automatic int unsigned rand_out(int unsigned side);
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return 1023;
      2:       return $urandom_range(0, 4095);
      default: return $urandom_range(1, side + 2);
    endcase
  endfunction

  task automatic random_phases();
    geom_t       g;
    int          stop_at;
    bit          first_phase;
    bit          wrote;
    bit          marked;
    int unsigned npix, len, noise, budget;
    stop_at     = n_queued + RANDOM_PIXELS;
    first_phase = 1'b1;
    while (n_queued < stop_at) begin
      wrote = first_phase;
      if (first_phase || $urandom_range(0, 1))
        push_cfg(rgbcrt_pkg::REG_FRAME_WIDTH, cfg_word_t'(rand_dim()));
      if (first_phase || $urandom_range(0, 1))
        push_cfg(rgbcrt_pkg::REG_FRAME_HEIGHT, cfg_word_t'(rand_dim()));
      g = crop_geometry(plan_regs);
      if (first_phase || $urandom_range(0, 1)) begin
        push_cfg(rgbcrt_pkg::REG_OUT_WIDTH, cfg_word_t'(rand_out(g.side)));
        wrote = 1'b1;
      end
      if (first_phase || $urandom_range(0, 1))
        push_cfg(rgbcrt_pkg::REG_OUT_HEIGHT, cfg_word_t'(rand_out(g.side)));
      if (!wrote || $urandom_range(0, 1))
        push_cfg(rgbcrt_pkg::REG_OUT_FORMAT, cfg_word_t'($urandom_range(0, 3)));
      first_phase = 1'b0;
      g = crop_geometry(plan_regs);
      npix = g.fw * g.fh;
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 9))
          0: begin  // cut short
            len    = $urandom_range(1, npix);
            marked = 1'b1;
            noise  = 0;
          end
          1: begin  // rely on the wrap
            len    = npix;
            marked = 1'b0;
            noise  = 0;
          end
          default: begin
            len    = npix;
            marked = 1'b1;
            noise  = 4;
          end
        endcase
        // the last frame is trimmed to keep the pixel count on budget
        budget = (n_queued < stop_at) ? stop_at - n_queued : 0;
        if (budget != 0) stream_frame((len < budget) ? len : budget, marked, noise);
      end
    end
  endtask

  // ------------------------------------------------------------------ driver

  always @(negedge clk) begin
    stim_t head;
    logic  valid_nx;
    logic  write_nx;
    if (rst) begin
      pix_ch.valid <= 1'b0;
      cfg_write    <= 1'b0;
      res_ch.ready <= 1'b0;
    end else begin
      tick++;
      calm     = (tick >= CALM_FROM) && (tick < CALM_TO);
      valid_nx = pix_ch.valid && (n_sent != n_taken);
      write_nx = 1'b0;
      if (!valid_nx && pix_ch.ready && expected_q.size() == 0) quiet++;
      else quiet = 0;
      if (!valid_nx && pending_q.size() != 0) begin
        head = pending_q[0];
        if (head.kind == ITEM_CFG) begin
          // registers only change once the pipe has fully drained
          if (quiet >= DRAIN_CYCLES) begin
            void'(pending_q.pop_front());
            write_nx  = 1'b1;
            cfg_index <= head.index;
            cfg_data  <= head.data;
            quiet     = 0;
          end
        end else if (calm || $urandom_range(0, 99) >= IDLE_PCT) begin
          void'(pending_q.pop_front());
          valid_nx = 1'b1;
          pix_ch.pixel          <= head.pixel;
          pix_ch.first_of_frame <= head.first;
          n_sent++;
        end
      end
      pix_ch.valid <= valid_nx;
      cfg_write    <= write_nx;
      res_ch.ready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
    end
  end

  // ----------------------------------------------------------------- monitor

  always @(posedge clk) begin
    rgbcrt_pkg::res_t want;
    if (rst) begin
      model_regs = REGS_AT_RESET;
      col_pos    = 0;
      row_pos    = 0;
      out_col    = 0;
      out_row    = 0;
      want_col   = 0;
      want_row   = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with nothing expected: x=%0d y=%0d",
                 res_ch.out_x, res_ch.out_y);
          n_fail++;
        end else begin
          want = expected_q.pop_front();
          check_field("red", 32'(want.red), 32'(res_ch.red));
          check_field("green", 32'(want.green), 32'(res_ch.green));
          check_field("blue", 32'(want.blue), 32'(res_ch.blue));
          check_field("out_x", 32'(want.out_x), 32'(res_ch.out_x));
          check_field("out_y", 32'(want.out_y), 32'(res_ch.out_y));
          check_field("last_of_frame", 32'(want.last_of_frame),
                      32'(res_ch.last_of_frame));
        end
      end
      if (cfg_write) model_regs = write_reg(model_regs, cfg_index, cfg_data);
      if (pix_ch.valid && pix_ch.ready) begin
        n_taken++;
        sample_pixel(pix_ch.pixel, pix_ch.first_of_frame);
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst                   = 1'b1;
    pix_ch.valid          = 1'b0;
    pix_ch.pixel          = '0;
    pix_ch.first_of_frame = 1'b0;
    res_ch.ready          = 1'b0;
    cfg_write             = 1'b0;
    cfg_index             = '0;
    cfg_data              = '0;

    // 2x2 frame, every pixel sampled, one pass per format
    push_cfg(rgbcrt_pkg::REG_FRAME_WIDTH, 12'd2);
    push_cfg(rgbcrt_pkg::REG_FRAME_HEIGHT, 12'd2);
    push_cfg(rgbcrt_pkg::REG_OUT_WIDTH, 12'd2);
    push_cfg(rgbcrt_pkg::REG_OUT_HEIGHT, 12'd2);
    push_cfg(rgbcrt_pkg::REG_OUT_FORMAT, cfg_word_t'(rgbcrt_pkg::FMT_UNSIGNED));
    push_pixel(16'h0000, 1'b1);
    push_pixel(16'hFFFF, 1'b0);
    push_pixel(16'hF800, 1'b0);
    push_pixel(16'h07E0, 1'b0);
    push_cfg(rgbcrt_pkg::REG_OUT_FORMAT, cfg_word_t'(rgbcrt_pkg::FMT_OFFSET));
    push_pixel(16'h001F, 1'b1);
    push_pixel(16'hFFFF, 1'b0);
    push_pixel(16'h0000, 1'b0);
    push_pixel(16'h8410, 1'b0);
    push_cfg(rgbcrt_pkg::REG_OUT_FORMAT, cfg_word_t'(rgbcrt_pkg::FMT_Q15));
    push_pixel(16'hFFFF, 1'b1);
    push_pixel(16'h0841, 1'b0);
    push_pixel(16'h0000, 1'b0);
    push_pixel(16'h7BEF, 1'b0);
    // format 3, dead index, mid-frame mark and then an unmarked wrap
    push_cfg(rgbcrt_pkg::REG_OUT_FORMAT, cfg_word_t'(FMT_ALIAS));
    push_cfg(REG_SPARE, 12'hFFF);
    push_cfg(rgbcrt_pkg::REG_FRAME_WIDTH, 12'd3);
    push_cfg(rgbcrt_pkg::REG_FRAME_HEIGHT, 12'd3);
    push_cfg(rgbcrt_pkg::REG_OUT_WIDTH, 12'd2);
    push_cfg(rgbcrt_pkg::REG_OUT_HEIGHT, 12'd3);
    push_pixel(16'hFFFF, 1'b1);
    push_pixel(16'hA5A5, 1'b0);
    stream_frame(9, 1'b1, 0);
    push_pixel(16'h5A5A, 1'b0);
    push_pixel(16'hFFFF, 1'b0);

    // oversize frame and output sizes: 2048 square crop, 512 samples across
    // one row, so every fourth column of the head of row 0 is taken
    push_cfg(rgbcrt_pkg::REG_FRAME_WIDTH, 12'hFFF);
    push_cfg(rgbcrt_pkg::REG_FRAME_HEIGHT, 12'hFFF);
    push_cfg(rgbcrt_pkg::REG_OUT_WIDTH, 12'd1023);
    push_cfg(rgbcrt_pkg::REG_OUT_HEIGHT, 12'd0);
    push_cfg(rgbcrt_pkg::REG_OUT_FORMAT, cfg_word_t'(rgbcrt_pkg::FMT_Q15));
    stream_frame(120, 1'b1, 0);
    // zero width against a five-row frame: single sample at row 2
    push_cfg(rgbcrt_pkg::REG_FRAME_WIDTH, 12'd0);
    push_cfg(rgbcrt_pkg::REG_FRAME_HEIGHT, 12'd5);
    push_cfg(rgbcrt_pkg::REG_OUT_WIDTH, 12'd0);
    push_cfg(rgbcrt_pkg::REG_OUT_HEIGHT, 12'd0);
    push_cfg(rgbcrt_pkg::REG_OUT_FORMAT, cfg_word_t'(rgbcrt_pkg::FMT_OFFSET));
    stream_frame(5, 1'b1, 0);

    random_phases();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_q.size() != 0 || n_sent != n_taken || expected_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (n_fail == 0) begin
      $display("rgb565_crop_resize_tensorizer test passed");
    end else begin
      $display("rgb565_crop_resize_tensorizer test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("rgb565_crop_resize_tensorizer test failed");
    $finish;
  end

endmodule
